// ----- rtl/secure_module_reply_frame_locator_macros.svh -----
// assertion macros used by the checker
`ifndef SECURE_MODULE_REPLY_FRAME_LOCATOR_MACROS_SVH
`define SECURE_MODULE_REPLY_FRAME_LOCATOR_MACROS_SVH

// same-cycle implication
`define SMRFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smrfl check failed");

// next-cycle implication
`define SMRFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smrfl check failed");

`endif

// ----- rtl/smrfl_pkg.sv -----
package smrfl_pkg;

	localparam int PREFIX_BASE   = 5;
	localparam int MAX_FRAME_LEN = 512;
	localparam int HDR_DEPTH     = PREFIX_BASE + 7;
	localparam int CNT_W         = $clog2(MAX_FRAME_LEN + 1);
	localparam int HDR_IDX_W     = $clog2(HDR_DEPTH);

	localparam logic [7:0] TAG_RESP = 8'hBD;
	localparam logic [7:0] TAG_LONG = 8'h81;
	localparam logic [7:0] TAG_NODE = 8'hA1;
	localparam logic [7:0] TAG_DONE = 8'h82;
	localparam logic [7:0] TAG_DATA = 8'h80;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       end_of_frame;
	} in_beat_t;

	typedef struct packed {
		logic [9:0] frame_length;
		logic       length_overflow;
		logic [2:0] node_offset;
		logic [2:0] span_offset;
		logic [9:0] payload_length;
		logic [2:0] prefix_length;
		logic       relay_pending;
		logic       relay_complete;
		logic [3:0] command_offset;
		logic [7:0] command_length;
	} out_beat_t;

	// header bytes and count as seen after the current beat is taken in
	typedef struct packed {
		logic [HDR_DEPTH-1:0][7:0] hdr;
		logic [CNT_W-1:0]          len;
		logic                      ovf;
	} frame_view_t;

endpackage

// ----- rtl/smrfl_capture.sv -----
module smrfl_capture (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  smrfl_pkg::in_beat_t   beat,
	output smrfl_pkg::frame_view_t view
);
	import smrfl_pkg::*;

	logic [HDR_DEPTH-1:0][7:0] hdr_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      ovf_q;
	logic                      at_max;

	assign at_max = (cnt_q == CNT_W'(MAX_FRAME_LEN));

	always_comb begin
		for (int i = 0; i < HDR_DEPTH; i++) begin
			view.hdr[i] = (cnt_q == CNT_W'(i)) ? beat.frame_byte : hdr_q[i];
		end
		view.len = at_max ? cnt_q : cnt_q + CNT_W'(1);
		view.ovf = ovf_q | at_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (commit) begin
			hdr_q <= view.hdr;
			// frame end: start the next frame from an empty count
			if (beat.end_of_frame) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= view.len;
				ovf_q <= view.ovf;
			end
		end
	end

endmodule

// ----- rtl/smrfl_decode.sv -----
module smrfl_decode (
	input  smrfl_pkg::frame_view_t view,
	output smrfl_pkg::out_beat_t   res
);
	import smrfl_pkg::*;

	localparam int AW = CNT_W + 1;

	logic [AW-1:0]        len;
	logic [1:0]           rn_counted, rn_exact, pf_cand, pf_exact;
	logic                 node_found, node_sel, pf_sel;
	logic [AW-1:0]        pofs, plen, pfx;
	logic [HDR_IDX_W-1:0] pi1, pi2, q0, q2, q4, q5;
	logic [7:0]           cmd_n;

	assign len = AW'(view.len);

	// candidate node positions at base and base+1
	always_comb begin
		int         o;
		logic       is_long;
		logic [7:0] nl;
		for (int k = 0; k < 2; k++) begin
			o       = PREFIX_BASE + k;
			is_long = (view.hdr[HDR_IDX_W'(o + 1)] == TAG_LONG);
			nl      = is_long ? view.hdr[HDR_IDX_W'(o + 2)] : view.hdr[HDR_IDX_W'(o + 1)];
			// a long-form mark with no length byte is not a match
			rn_counted[k] = (AW'(o + 1) < len) && (view.hdr[HDR_IDX_W'(o)] == TAG_RESP) &&
				(!is_long || (AW'(o + 2) < len));
			rn_exact[k] = rn_counted[k] &&
				((AW'(o + (is_long ? 5 : 4)) + AW'(nl)) == len);
			pf_cand[k] = (AW'(o + 1) < len) &&
				((view.hdr[HDR_IDX_W'(o)] == TAG_NODE) ||
				(view.hdr[HDR_IDX_W'(o)] == TAG_RESP));
			pf_exact[k] = pf_cand[k] &&
				((AW'(o + 4) + AW'(view.hdr[HDR_IDX_W'(o + 1)])) == len);
		end
	end

	// exact length match wins over a plain tag match
	always_comb begin
		node_found = 1'b1;
		node_sel   = 1'b0;
		if (rn_exact[0]) begin
			node_sel = 1'b0;
		end else if (rn_exact[1]) begin
			node_sel = 1'b1;
		end else if (rn_counted[0]) begin
			node_sel = 1'b0;
		end else if (rn_counted[1]) begin
			node_sel = 1'b1;
		end else begin
			node_found = 1'b0;
		end

		if (pf_exact[0]) begin
			pf_sel = 1'b0;
		end else if (pf_exact[1]) begin
			pf_sel = 1'b1;
		end else if (pf_cand[0]) begin
			pf_sel = 1'b0;
		end else if (pf_cand[1]) begin
			pf_sel = 1'b1;
		end else begin
			pf_sel = 1'b0;
		end
	end

	// payload span
	always_comb begin
		pofs = AW'(PREFIX_BASE) + AW'(node_sel);
		pi1  = HDR_IDX_W'(PREFIX_BASE + 1) + HDR_IDX_W'(node_sel);
		pi2  = HDR_IDX_W'(PREFIX_BASE + 2) + HDR_IDX_W'(node_sel);
		if (((pofs + AW'(2)) < len) && (view.hdr[pi1] == TAG_LONG)) begin
			plen = AW'(view.hdr[pi2]) + AW'(3);
		end else if ((pofs + AW'(1)) < len) begin
			plen = AW'(view.hdr[pi1]) + AW'(2);
		end else begin
			plen = '0;
		end
		if ((pofs + plen) > len) begin
			plen = (len > pofs) ? len - pofs : '0;
		end
	end

	// relay flags and embedded command
	always_comb begin
		pfx   = AW'(PREFIX_BASE) + AW'(pf_sel);
		q0    = HDR_IDX_W'(PREFIX_BASE) + HDR_IDX_W'(pf_sel);
		q2    = HDR_IDX_W'(PREFIX_BASE + 2) + HDR_IDX_W'(pf_sel);
		q4    = HDR_IDX_W'(PREFIX_BASE + 4) + HDR_IDX_W'(pf_sel);
		q5    = HDR_IDX_W'(PREFIX_BASE + 5) + HDR_IDX_W'(pf_sel);
		cmd_n = view.hdr[q5];

		res.frame_length    = 10'(view.len);
		res.length_overflow = view.ovf;
		res.node_offset     = node_found ? 3'(pofs) : 3'd0;
		res.span_offset     = 3'(pofs);
		res.payload_length  = 10'(plen);
		res.prefix_length   = 3'(pfx);
		res.relay_pending   = ((pfx + AW'(4)) < len) && (view.hdr[q0] == TAG_NODE) &&
			(view.hdr[q2] == TAG_NODE) && (view.hdr[q4] == TAG_DATA);
		res.relay_complete  = ((pfx + AW'(2)) < len) && (view.hdr[q0] == TAG_NODE) &&
			(view.hdr[q2] == TAG_DONE);
		if (((pfx + AW'(5)) < len) && ((pfx + AW'(6) + AW'(cmd_n)) <= len)) begin
			res.command_offset = 4'(pfx + AW'(6));
			res.command_length = cmd_n;
		end else begin
			res.command_offset = 4'd0;
			res.command_length = 8'd0;
		end
	end

endmodule

// ----- rtl/secure_module_reply_frame_locator.sv -----
// channel | dir | handshake                  | beat
// frame   | in  | frame_valid, frame_ready   | frame_beat: frame_byte, end_of_frame
// result  | out | result_valid, result_ready | result: one per frame, on the last byte
//
// one byte per cycle sustained, unless a last byte waits for room in the output
// register; a byte is held in the input register, then updates the header store and
// count; the last byte's result is loaded into the output register at that update.
// reset clears the count, overflow flag, header store and both valid flags.
// a waiting result stalls input only when another frame's last byte reaches it.
module secure_module_reply_frame_locator (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	output logic                  frame_ready,
	input  smrfl_pkg::in_beat_t   frame_beat,
	output logic                  result_valid,
	input  logic                  result_ready,
	output smrfl_pkg::out_beat_t  result
);
	import smrfl_pkg::*;

	logic        valid_s1;
	in_beat_t    beat_s1;
	logic        advance;
	logic        commit;
	frame_view_t view;
	out_beat_t   res_d;
	logic        result_valid_q;
	out_beat_t   result_q;

	// only a last byte needs room in the output register
	assign advance     = !valid_s1 || !beat_s1.end_of_frame || !result_valid_q || result_ready;
	assign frame_ready = advance;
	assign commit      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= frame_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_valid) begin
			beat_s1 <= frame_beat;
		end
	end

	smrfl_capture u_capture (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.beat   (beat_s1),
		.view   (view)
	);

	smrfl_decode u_decode (
		.view (view),
		.res  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit && beat_s1.end_of_frame) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && beat_s1.end_of_frame) begin
			result_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- rtl/smrfl_checker.sv -----
`include "secure_module_reply_frame_locator_macros.svh"

module smrfl_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 frame_valid,
	input logic                 frame_ready,
	input smrfl_pkg::in_beat_t  frame_beat,
	input logic                 result_valid,
	input logic                 result_ready,
	input smrfl_pkg::out_beat_t result
);
	import smrfl_pkg::*;

	`SMRFL_ASSERT_NEXT(a_result_hold, clk, arst_n,
		result_valid && !result_ready, result_valid && $stable(result))
	`SMRFL_ASSERT_NOW(a_node_is_span, clk, arst_n,
		result_valid && (result.node_offset != 3'd0),
		result.node_offset == result.span_offset)
	`SMRFL_ASSERT_NOW(a_cmd_after_prefix, clk, arst_n,
		result_valid && (result.command_offset != 4'd0),
		result.command_offset == ({1'b0, result.prefix_length} + 4'd6))
	`SMRFL_ASSERT_NOW(a_ovf_saturated, clk, arst_n,
		result_valid && result.length_overflow,
		result.frame_length == 10'(MAX_FRAME_LEN))

endmodule

bind secure_module_reply_frame_locator smrfl_checker u_smrfl_checker (.*);
